[sv/sabtb_pkg.sv]
// shared constants, types and helpers for the set-associative branch target buffer
`timescale 1ns / 1ps
`default_nettype none
package sabtb_pkg;

	// geometry of the store
	localparam int TOTAL_ENTRIES  = 1024;
	localparam int NUM_WAYS       = 4;
	localparam int SET_COUNT      = TOTAL_ENTRIES / NUM_WAYS;
	localparam int PC_INDEX_SHIFT = 2;

	localparam int SET_W  = (SET_COUNT > 1) ? $clog2(SET_COUNT) : 1;
	localparam int WAY_W  = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
	localparam int LINE_W = (TOTAL_ENTRIES > 1) ? $clog2(TOTAL_ENTRIES) : 1;

	// field widths of the items
	localparam int PC_W      = 64;
	localparam int SIZE_W    = 4;
	localparam int KIND_W    = 3;
	localparam int STAMP_W   = 32;
	localparam int SET_IDX_W = 8;
	localparam int WAY_IDX_W = 2;

	// operation codes
	localparam logic FUNC_LOOKUP  = 1'b0;
	localparam logic FUNC_INSTALL = 1'b1;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN
	} sabtb_state_t;

	typedef logic [LINE_W-1:0]   line_addr_t;
	typedef logic [SET_W-1:0]    set_addr_t;
	typedef logic [WAY_W-1:0]    way_t;
	typedef logic [NUM_WAYS-1:0] way_row_t;

	// line write request toward the store
	typedef struct packed {
		logic                line_we;
		logic                stamp_we;
		line_addr_t          addr;
		logic [PC_W-1:0]     tag;
		logic [PC_W-1:0]     target;
		logic [KIND_W-1:0]   kind;
		logic [STAMP_W-1:0]  stamp;
	} sabtb_wr_t;

	// valid row write request toward the store
	typedef struct packed {
		logic      we;
		set_addr_t addr;
		way_row_t  bits;
	} sabtb_vwr_t;

	// set selected by a pc
	function automatic set_addr_t set_of(input logic [PC_W-1:0] pc);
		logic [PC_W-1:0] sh;
		sh = (pc >> PC_INDEX_SHIFT) & PC_W'(SET_COUNT - 1);
		return sh[SET_W-1:0];
	endfunction

	// flat line address of a way in a set
	function automatic line_addr_t line_of(input set_addr_t set, input way_t way);
		int flat;
		flat = int'(set) * NUM_WAYS + int'(way);
		return LINE_W'(flat);
	endfunction

endpackage
`default_nettype wire

[sv/sabtb_cmp.sv]
// shared comparator used for tag match and stamp ordering
`timescale 1ns / 1ps
`default_nettype none
module sabtb_cmp (
	input  wire logic [sabtb_pkg::PC_W-1:0] opa,
	input  wire logic [sabtb_pkg::PC_W-1:0] opb,
	output logic                            eq,
	output logic                            lt
);
	import sabtb_pkg::*;

	// one equality and one unsigned less-than on the selected operands
	always_comb begin
		eq = (opa == opb);
		lt = (opa < opb);
	end

endmodule
`default_nettype wire

[sv/sabtb_store.sv]
// line store: valid rows, tags, targets, kinds and stamps
`timescale 1ns / 1ps
`default_nettype none
module sabtb_store (
	input  wire logic                             clk,
	input  wire sabtb_pkg::set_addr_t             vrd_addr,
	input  wire sabtb_pkg::line_addr_t            rd_addr,
	input  wire sabtb_pkg::sabtb_vwr_t            vwr,
	input  wire sabtb_pkg::sabtb_wr_t             wr,
	output sabtb_pkg::way_row_t                   vrd_row,
	output logic [sabtb_pkg::PC_W-1:0]            rd_tag,
	output logic [sabtb_pkg::STAMP_W-1:0]         rd_stamp
);
	import sabtb_pkg::*;

	way_row_t             valid_mem  [SET_COUNT];
	logic [PC_W-1:0]      tag_mem    [TOTAL_ENTRIES];
	logic [PC_W-1:0]      target_mem [TOTAL_ENTRIES];
	logic [KIND_W-1:0]    kind_mem   [TOTAL_ENTRIES];
	logic [STAMP_W-1:0]   stamp_mem  [TOTAL_ENTRIES];

	// valid rows, one row per set
	always_ff @(posedge clk) begin
		if (vwr.we) begin
			valid_mem[vwr.addr] <= vwr.bits;
		end
		vrd_row <= valid_mem[vrd_addr];
	end

	// line payload
	always_ff @(posedge clk) begin
		if (wr.line_we) begin
			tag_mem[wr.addr]    <= wr.tag;
			target_mem[wr.addr] <= wr.target;
			kind_mem[wr.addr]   <= wr.kind;
		end
		rd_tag <= tag_mem[rd_addr];
	end

	// last-use stamps, also refreshed on a lookup hit
	always_ff @(posedge clk) begin
		if (wr.line_we || wr.stamp_we) begin
			stamp_mem[wr.addr] <= wr.stamp;
		end
		rd_stamp <= stamp_mem[rd_addr];
	end

endmodule
`default_nettype wire

[sv/set_assoc_branch_target_buffer.sv]
// top level: sequencer that walks the ways of a set through the shared comparator
//
//  channel | signals                                         | dir
//  in      | in_valid in_ready func pc instr_size branch_kind time_stamp | in
//  out     | out_valid out_ready hit set_index way_index     | out
//
//  an item is accepted in ST_IDLE, then ST_SCAN visits the ways of its set in order,
//  one way at a time; the single read port of the line store sets this.
//  after reset a clearing pass zeroes the valid rows of every set;
//  no item is taken until it ends.
//  a new item is taken while a result waits; the walk holds at the way where it
//  finishes until the output register is free.
`timescale 1ns / 1ps
`default_nettype none
module set_assoc_branch_target_buffer (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic                              func,
	input  wire logic [sabtb_pkg::PC_W-1:0]        pc,
	input  wire logic [sabtb_pkg::SIZE_W-1:0]      instr_size,
	input  wire logic [sabtb_pkg::KIND_W-1:0]      branch_kind,
	input  wire logic [sabtb_pkg::STAMP_W-1:0]     time_stamp,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic                                   hit,
	output logic [sabtb_pkg::SET_IDX_W-1:0]        set_index,
	output logic [sabtb_pkg::WAY_IDX_W-1:0]        way_index
);
	import sabtb_pkg::*;

	sabtb_state_t         state_q, state_d;
	set_addr_t            clr_q;
	way_t                 way_q;
	way_t                 best_way_q;
	logic [STAMP_W-1:0]   best_stamp_q;

	// latched item
	logic                 func_q;
	logic [PC_W-1:0]      pc_q;
	logic [SIZE_W-1:0]    size_q;
	logic [KIND_W-1:0]    kind_q;
	logic [STAMP_W-1:0]   stamp_q;
	set_addr_t            set_q;

	// result register
	logic                 out_valid_q;
	logic                 res_hit_q;
	set_addr_t            res_set_q;
	way_t                 res_way_q;

	// store and comparator hookup
	set_addr_t            vrd_addr;
	line_addr_t           rd_addr;
	sabtb_vwr_t           vwr;
	sabtb_wr_t            wr;
	way_row_t             vrd_row;
	logic [PC_W-1:0]      rd_tag;
	logic [STAMP_W-1:0]   rd_stamp;
	logic [PC_W-1:0]      opa, opb;
	logic                 cmp_eq, cmp_lt;

	// sequencer controls
	logic                 accept;
	logic                 out_free;
	logic                 last_way;
	logic                 cur_valid;
	logic                 hit_now;
	logic                 finish;
	logic                 go;
	logic                 advance;
	logic                 better;
	way_t                 cand_way;
	way_t                 victim;
	way_t                 rd_way;
	logic                 res_hit_d;
	way_t                 res_way_d;

	sabtb_store u_store (
		.clk      (clk),
		.vrd_addr (vrd_addr),
		.rd_addr  (rd_addr),
		.vwr      (vwr),
		.wr       (wr),
		.vrd_row  (vrd_row),
		.rd_tag   (rd_tag),
		.rd_stamp (rd_stamp)
	);

	sabtb_cmp u_cmp (
		.opa (opa),
		.opb (opb),
		.eq  (cmp_eq),
		.lt  (cmp_lt)
	);

	// comparator operands: tag against pc, or stamp against best so far
	always_comb begin
		if (func_q == FUNC_LOOKUP) begin
			opa = rd_tag;
			opb = pc_q;
		end else begin
			opa = PC_W'(rd_stamp);
			opb = PC_W'(best_stamp_q);
		end
	end

	// per-way decisions
	always_comb begin
		out_free  = !out_valid_q || out_ready;
		last_way  = (way_q == WAY_W'(NUM_WAYS - 1));
		cur_valid = vrd_row[way_q];
		hit_now   = cur_valid && cmp_eq;
		better    = (way_q == '0) || cmp_lt;
		cand_way  = better ? way_q : best_way_q;
		victim    = cur_valid ? cand_way : way_q;
		if (func_q == FUNC_LOOKUP) begin
			finish    = hit_now || last_way;
			res_hit_d = hit_now;
			res_way_d = hit_now ? way_q : '0;
		end else begin
			finish    = !cur_valid || last_way;
			res_hit_d = 1'b1;
			res_way_d = victim;
		end
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and store requests
	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		accept   = 1'b0;
		go       = 1'b0;
		advance  = 1'b0;
		rd_way   = '0;
		vrd_addr = set_q;
		vwr      = '0;
		wr       = '0;
		wr.tag    = pc_q;
		wr.target = pc_q + PC_W'(size_q);
		wr.kind   = kind_q;
		wr.stamp  = stamp_q;
		case (state_q)
			ST_CLEAR: begin
				vwr.we   = 1'b1;
				vwr.addr = clr_q;
				vwr.bits = '0;
				if (clr_q == SET_W'(SET_COUNT - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				accept   = in_valid;
				vrd_addr = set_of(pc);
				if (in_valid) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				go      = finish && out_free;
				advance = !finish;
				rd_way  = advance ? way_q + WAY_W'(1) : way_q;
				if (go) begin
					state_d = ST_IDLE;
					if (func_q == FUNC_LOOKUP) begin
						wr.stamp_we = hit_now;
						wr.addr     = line_of(set_q, way_q);
					end else begin
						wr.line_we = 1'b1;
						wr.addr    = line_of(set_q, victim);
						vwr.we     = 1'b1;
						vwr.addr   = set_q;
						vwr.bits   = vrd_row | (NUM_WAYS'(1) << victim);
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		rd_addr = (state_q == ST_IDLE) ? line_of(set_of(pc), '0) : line_of(set_q, rd_way);
	end

	// clearing pass counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (state_q == ST_CLEAR) begin
			clr_q <= clr_q + SET_W'(1);
		end
	end

	// way walk and best-stamp tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			way_q      <= '0;
			best_way_q <= '0;
		end else if (accept) begin
			way_q      <= '0;
			best_way_q <= '0;
		end else if (state_q == ST_SCAN && advance) begin
			way_q      <= way_q + WAY_W'(1);
			best_way_q <= cand_way;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_SCAN && advance && better) begin
			best_stamp_q <= rd_stamp;
		end
	end

	// latch the accepted item
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q  <= func;
			pc_q    <= pc;
			size_q  <= instr_size;
			kind_q  <= branch_kind;
			stamp_q <= time_stamp;
			set_q   <= set_of(pc);
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			res_hit_q <= res_hit_d;
			res_set_q <= set_q;
			res_way_q <= res_way_d;
		end
	end

	// output ports
	assign out_valid = out_valid_q;
	assign hit       = res_hit_q;
	assign set_index = SET_IDX_W'(res_set_q);
	assign way_index = WAY_IDX_W'(res_way_q);

endmodule
`default_nettype wire
